// ===== hdl/symplectic_euler_particle_step_core_defines.svh =====
// Assertion macros used by the integrator top level.
`ifndef SYMPLECTIC_EULER_PARTICLE_STEP_CORE_DEFINES_SVH
`define SYMPLECTIC_EULER_PARTICLE_STEP_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define SEPI_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sepi assertion failed");
`define SEPI_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("sepi forbidden condition");
`else
`define SEPI_ASSERT(lbl, clk, rst_n, prop)
`define SEPI_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== hdl/sepi_pkg.sv =====
// Shared constants and types for the symplectic Euler integrator.
package sepi_pkg;
  localparam int unsigned Q_W    = 32;
  localparam int unsigned DT_W   = 17;
  localparam int unsigned MASS_W = 31;
  localparam int unsigned NUM_W  = 48;
  localparam int unsigned AXES   = 3;
  localparam logic [DT_W-1:0] DT_MAX   = 17'd65536;
  localparam logic [DT_W-1:0] DT_RESET = 17'd1092;

  typedef logic [Q_W-1:0] q_t;

  typedef struct packed {
    logic [AXES-1:0][Q_W-1:0] pos;
    logic [AXES-1:0][Q_W-1:0] vel;
    logic [AXES-1:0]          fneg;
  } side_t;
endpackage

// ===== hdl/symplectic_euler_particle_step_core.sv =====
// Top level of the symplectic Euler particle integrator.
// One particle word per cycle enters on in_* (valid/ready): position, velocity
// and force on three axes (Q16.16) plus mass (Q15.16). Each word yields one result
// word on out_*: new velocity v' = v + f*dt/m, then new position p' = p + v'*dt,
// each saturated to 32 bits, with overflow set if any component saturated.
// dt is written through cfg_wr_en/cfg_wr_data (values above 1.0 clamp to 1.0)
// and must only change while the pipeline is empty.
// The word crosses 53 registers: input register (loaded at the accepting
// edge), force product, 48 divider stages (one quotient bit each, the bulk of
// the depth), velocity update, velocity product and position update/output
// register.
// Throughput is one word per cycle with out_ready held high.
// When the receiver stalls, every stage holds and in_ready drops until the
// output register is taken; nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and sets dt to 1092.
module symplectic_euler_particle_step_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [sepi_pkg::DT_W-1:0]      cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sepi_pkg::Q_W-1:0]       in_pos_x,
  input  logic [sepi_pkg::Q_W-1:0]       in_pos_y,
  input  logic [sepi_pkg::Q_W-1:0]       in_pos_z,
  input  logic [sepi_pkg::Q_W-1:0]       in_vel_x,
  input  logic [sepi_pkg::Q_W-1:0]       in_vel_y,
  input  logic [sepi_pkg::Q_W-1:0]       in_vel_z,
  input  logic [sepi_pkg::Q_W-1:0]       in_force_x,
  input  logic [sepi_pkg::Q_W-1:0]       in_force_y,
  input  logic [sepi_pkg::Q_W-1:0]       in_force_z,
  input  logic [sepi_pkg::MASS_W-1:0]    in_mass,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sepi_pkg::Q_W-1:0]       out_new_pos_x,
  output logic [sepi_pkg::Q_W-1:0]       out_new_pos_y,
  output logic [sepi_pkg::Q_W-1:0]       out_new_pos_z,
  output logic [sepi_pkg::Q_W-1:0]       out_new_vel_x,
  output logic [sepi_pkg::Q_W-1:0]       out_new_vel_y,
  output logic [sepi_pkg::Q_W-1:0]       out_new_vel_z,
  output logic                           out_overflow
);
  import sepi_pkg::*;
  `include "symplectic_euler_particle_step_core_defines.svh"

  localparam int unsigned SUM_W = 50;
  localparam logic signed [SUM_W-1:0] SAT_HI = 50'sd2147483647;
  localparam logic signed [SUM_W-1:0] SAT_LO = -50'sd2147483648;

  // {flag, value}
  function automatic logic [Q_W:0] sat_q(input logic signed [SUM_W-1:0] v);
    logic [Q_W:0] r;
    if (v > SAT_HI) begin
      r = {1'b1, SAT_HI[Q_W-1:0]};
    end else if (v < SAT_LO) begin
      r = {1'b1, SAT_LO[Q_W-1:0]};
    end else begin
      r = {1'b0, v[Q_W-1:0]};
    end
    return r;
  endfunction

  function automatic logic [Q_W-1:0] mag_q(input logic [Q_W-1:0] x);
    logic [Q_W:0] t;
    t = x[Q_W-1] ? (~{1'b1, x} + 1'b1) : {1'b0, x};
    return t[Q_W-1:0];
  endfunction

  logic              en;
  logic [DT_W-1:0]   dt_r;

  // stage a: input register
  logic                      a_vld_r;
  logic [AXES-1:0][Q_W-1:0]  a_pos_r, a_vel_r, a_f_r;
  logic [MASS_W-1:0]         a_m_r;
  // stage b: |f|*dt
  logic                          b_vld_r;
  logic [AXES-1:0][NUM_W-1:0]    b_num_r;
  logic [MASS_W-1:0]             b_den_r;
  side_t                         b_side_r;
  logic [AXES-1:0][NUM_W-1:0]    b_num_nxt;
  // divider output
  logic                          q_vld;
  logic [AXES-1:0][NUM_W-1:0]    q_quo;
  side_t                         q_side;
  // stage c: new velocity
  logic                      c_vld_r, c_ovf_r;
  logic [AXES-1:0][Q_W-1:0]  c_nv_r, c_pos_r;
  logic [AXES-1:0][Q_W-1:0]  c_nv_nxt;
  logic                      c_ovf_nxt;
  // stage d: position increment
  logic                      d_vld_r, d_ovf_r;
  logic [AXES-1:0][Q_W-1:0]  d_inc_r, d_pos_r, d_nv_r;
  logic [AXES-1:0]           d_neg_r;
  logic [AXES-1:0][Q_W-1:0]  d_inc_nxt;
  // output register
  logic                      o_vld_r, o_ovf_r;
  logic [AXES-1:0][Q_W-1:0]  o_pos_r, o_vel_r;
  logic [AXES-1:0][Q_W-1:0]  o_pos_nxt;
  logic                      o_ovf_nxt;

  assign en       = !o_vld_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= DT_RESET;
    end else if (cfg_wr_en) begin
      dt_r <= (cfg_wr_data > DT_MAX) ? DT_MAX : cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
      b_vld_r <= a_vld_r;
      c_vld_r <= q_vld;
      d_vld_r <= c_vld_r;
      o_vld_r <= d_vld_r;
    end
  end

  always_comb begin
    logic [Q_W+DT_W-1:0] prod;
    for (int a = 0; a < AXES; a++) begin
      prod         = {{DT_W{1'b0}}, mag_q(a_f_r[a])} * {{Q_W{1'b0}}, dt_r};
      b_num_nxt[a] = prod[NUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_pos_r <= {in_pos_z, in_pos_y, in_pos_x};
      a_vel_r <= {in_vel_z, in_vel_y, in_vel_x};
      a_f_r   <= {in_force_z, in_force_y, in_force_x};
      // zero mass is taken as one LSB
      a_m_r   <= (in_mass == '0) ? MASS_W'(1) : in_mass;
      b_num_r <= b_num_nxt;
      b_den_r <= a_m_r;
      b_side_r.pos <= a_pos_r;
      b_side_r.vel <= a_vel_r;
      for (int a = 0; a < AXES; a++) begin
        b_side_r.fneg[a] <= a_f_r[a][Q_W-1];
      end
    end
  end

  sepi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (b_vld_r),
    .in_num   (b_num_r),
    .in_den   (b_den_r),
    .in_side  (b_side_r),
    .out_vld  (q_vld),
    .out_quo  (q_quo),
    .out_side (q_side)
  );

  always_comb begin
    logic signed [SUM_W-1:0] v, q, s;
    logic [Q_W:0]            r;
    c_ovf_nxt = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      v = SUM_W'(signed'(q_side.vel[a]));
      q = SUM_W'(q_quo[a]);
      s = q_side.fneg[a] ? (v - q) : (v + q);
      r = sat_q(s);
      c_nv_nxt[a] = r[Q_W-1:0];
      c_ovf_nxt   = c_ovf_nxt | r[Q_W];
    end
  end

  always_comb begin
    logic [Q_W+DT_W-1:0] prod;
    for (int a = 0; a < AXES; a++) begin
      prod         = {{DT_W{1'b0}}, mag_q(c_nv_r[a])} * {{Q_W{1'b0}}, dt_r};
      d_inc_nxt[a] = prod[NUM_W-1:NUM_W-Q_W];
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] p, i, s;
    logic [Q_W:0]            r;
    o_ovf_nxt = d_ovf_r;
    for (int a = 0; a < AXES; a++) begin
      p = SUM_W'(signed'(d_pos_r[a]));
      i = SUM_W'(d_inc_r[a]);
      s = d_neg_r[a] ? (p - i) : (p + i);
      r = sat_q(s);
      o_pos_nxt[a] = r[Q_W-1:0];
      o_ovf_nxt    = o_ovf_nxt | r[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_nv_r  <= c_nv_nxt;
      c_pos_r <= q_side.pos;
      c_ovf_r <= c_ovf_nxt;
      d_inc_r <= d_inc_nxt;
      d_pos_r <= c_pos_r;
      d_nv_r  <= c_nv_r;
      d_ovf_r <= c_ovf_r;
      for (int a = 0; a < AXES; a++) begin
        d_neg_r[a] <= c_nv_r[a][Q_W-1];
      end
      o_pos_r <= o_pos_nxt;
      o_vel_r <= d_nv_r;
      o_ovf_r <= o_ovf_nxt;
    end
  end

  assign out_valid     = o_vld_r;
  assign out_new_pos_x = o_pos_r[0];
  assign out_new_pos_y = o_pos_r[1];
  assign out_new_pos_z = o_pos_r[2];
  assign out_new_vel_x = o_vel_r[0];
  assign out_new_vel_y = o_vel_r[1];
  assign out_new_vel_z = o_vel_r[2];
  assign out_overflow  = o_ovf_r;

  `SEPI_ASSERT(a_stall_blocks_input, clk, rst_n, o_vld_r && !out_ready |-> !in_ready)
  `SEPI_NEVER(a_dt_in_range, clk, rst_n, dt_r > DT_MAX)
  `SEPI_ASSERT(a_out_from_pipe, clk, rst_n, $rose(o_vld_r) |-> $past(d_vld_r))
endmodule

// ===== hdl/sepi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, three lanes sharing a divisor.
module sepi_div (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     en,
  input  logic                                     in_vld,
  input  logic [sepi_pkg::AXES-1:0][sepi_pkg::NUM_W-1:0] in_num,
  input  logic [sepi_pkg::MASS_W-1:0]              in_den,
  input  sepi_pkg::side_t                          in_side,
  output logic                                     out_vld,
  output logic [sepi_pkg::AXES-1:0][sepi_pkg::NUM_W-1:0] out_quo,
  output sepi_pkg::side_t                          out_side
);
  import sepi_pkg::*;

  logic [NUM_W:1]                      vld_r;
  logic [AXES-1:0][MASS_W-1:0]         rem_r  [1:NUM_W];
  logic [AXES-1:0][NUM_W-1:0]          num_r  [1:NUM_W];
  logic [AXES-1:0][NUM_W-1:0]          quo_r  [1:NUM_W];
  logic [MASS_W-1:0]                   den_r  [1:NUM_W];
  side_t                               side_r [1:NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stg
    logic                        vin;
    logic [AXES-1:0][MASS_W-1:0] rin;
    logic [AXES-1:0][NUM_W-1:0]  nin;
    logic [AXES-1:0][NUM_W-1:0]  qin;
    logic [MASS_W-1:0]           din;
    side_t                       sin;
    logic [AXES-1:0][MASS_W-1:0] rem_nxt;
    logic [AXES-1:0][NUM_W-1:0]  num_nxt;
    logic [AXES-1:0][NUM_W-1:0]  quo_nxt;

    if (k == 0) begin : g_first
      assign vin = in_vld;
      assign rin = '0;
      assign nin = in_num;
      assign qin = '0;
      assign din = in_den;
      assign sin = in_side;
    end else begin : g_rest
      assign vin = vld_r[k];
      assign rin = rem_r[k];
      assign nin = num_r[k];
      assign qin = quo_r[k];
      assign din = den_r[k];
      assign sin = side_r[k];
    end

    always_comb begin
      logic [MASS_W:0] sh;
      logic            ge;
      for (int a = 0; a < AXES; a++) begin
        sh         = {rin[a], nin[a][NUM_W-1]};
        ge         = (sh >= {1'b0, din});
        rem_nxt[a] = ge ? MASS_W'(sh - {1'b0, din}) : sh[MASS_W-1:0];
        num_nxt[a] = {nin[a][NUM_W-2:0], 1'b0};
        quo_nxt[a] = {qin[a][NUM_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= rem_nxt;
        num_r[k+1]  <= num_nxt;
        quo_r[k+1]  <= quo_nxt;
        den_r[k+1]  <= din;
        side_r[k+1] <= sin;
      end
    end
  end

  assign out_vld  = vld_r[NUM_W];
  assign out_quo  = quo_r[NUM_W];
  assign out_side = side_r[NUM_W];
endmodule
